[rtl/dba_pkg.sv]
// Shared types and constants of the depth band average core.
// Used by every module of the block; depends on nothing.
package dba_pkg;

    localparam int unsigned MAX_FRAME_PIXELS = 262144;

    localparam int unsigned DEPTH_W  = 16;
    localparam int unsigned THRESH_W = 14;
    localparam int unsigned AVG_W    = 14;
    localparam int unsigned COUNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int unsigned SUM_W    = $clog2(MAX_FRAME_PIXELS) + THRESH_W;
    localparam int unsigned REM_W    = COUNT_W;
    localparam int unsigned STEP_W   = $clog2(AVG_W);

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_W     = ((AVG_W + COUNT_W + 7) / 8) * 8;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_NEAR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FAR  = CFG_IDX_W'(1);

    localparam logic [THRESH_W-1:0] NEAR_RESET = THRESH_W'(200);
    localparam logic [THRESH_W-1:0] FAR_RESET  = THRESH_W'(1000);

    // Accumulated totals of one finished frame
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } frame_sum_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } div_state_t;

endpackage

[rtl/dba_front.sv]
// Front end: threshold registers, in-band test and per-frame accumulation.
// Pushes one frame_sum_t per frame into the queue; uses dba_pkg.
module dba_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [dba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dba_pkg::THRESH_W-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dba_pkg::DEPTH_W-1:0]       s_tdata,
    input  logic                              s_tlast,
    input  dba_pkg::fifo_status_t             q_status,
    output logic                              push,
    output dba_pkg::frame_sum_t               push_data
);

    logic [dba_pkg::THRESH_W-1:0] near_reg;
    logic [dba_pkg::THRESH_W-1:0] near_next;
    logic [dba_pkg::THRESH_W-1:0] far_reg;
    logic [dba_pkg::THRESH_W-1:0] far_next;
    logic [dba_pkg::SUM_W-1:0]    sum_reg;
    logic [dba_pkg::SUM_W-1:0]    sum_next;
    logic [dba_pkg::COUNT_W-1:0]  count_reg;
    logic [dba_pkg::COUNT_W-1:0]  count_next;
    logic [dba_pkg::SUM_W-1:0]    sum_acc;
    logic [dba_pkg::COUNT_W-1:0]  count_acc;
    logic                         xfer;
    logic                         in_band;

    assign s_tready = !q_status.full;
    assign xfer     = s_tvalid && !q_status.full;

    // Counting stops at the frame limit so the sum cannot overflow
    assign in_band = (s_tdata >= dba_pkg::DEPTH_W'(near_reg))
                  && (s_tdata <= dba_pkg::DEPTH_W'(far_reg))
                  && (count_reg < dba_pkg::COUNT_W'(dba_pkg::MAX_FRAME_PIXELS));

    always_comb
    begin
        sum_acc   = sum_reg;
        count_acc = count_reg;
        if (in_band)
        begin
            sum_acc   = sum_reg + dba_pkg::SUM_W'(s_tdata);
            count_acc = count_reg + dba_pkg::COUNT_W'(1);
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (xfer)
        begin
            if (s_tlast)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
            end
        end
    end

    always_comb
    begin
        near_next = near_reg;
        far_next  = far_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                dba_pkg::REG_NEAR: near_next = cfg_data;
                dba_pkg::REG_FAR:  far_next  = cfg_data;
                default:
                begin
                    near_next = near_reg;
                    far_next  = far_reg;
                end
            endcase
        end
    end

    assign push            = xfer && s_tlast;
    assign push_data.sum   = sum_acc;
    assign push_data.count = count_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg  <= dba_pkg::NEAR_RESET;
            far_reg   <= dba_pkg::FAR_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            near_reg  <= near_next;
            far_reg   <= far_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dba_pkg::COUNT_W'(dba_pkg::MAX_FRAME_PIXELS))
        else $error("band count above frame limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (sum_reg == '0) && (count_reg == '0))
        else $error("accumulators not cleared after frame end");

endmodule

[rtl/dba_fifo.sv]
// Short queue of finished frame totals between front and back end.
// Uses dba_pkg for the entry type and depth.
module dba_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dba_pkg::frame_sum_t   push_data,
    input  logic                  pop,
    output dba_pkg::frame_sum_t   pop_data,
    output dba_pkg::fifo_status_t status
);

    dba_pkg::frame_sum_t              entry_reg [dba_pkg::FIFO_DEPTH];
    logic [dba_pkg::FIFO_PTR_W-1:0]   wptr_reg;
    logic [dba_pkg::FIFO_PTR_W-1:0]   wptr_next;
    logic [dba_pkg::FIFO_PTR_W-1:0]   rptr_reg;
    logic [dba_pkg::FIFO_PTR_W-1:0]   rptr_next;
    logic [dba_pkg::FIFO_CNT_W-1:0]   cnt_reg;
    logic [dba_pkg::FIFO_CNT_W-1:0]   cnt_next;
    logic                             do_push;
    logic                             do_pop;

    assign status.full  = (cnt_reg == dba_pkg::FIFO_CNT_W'(dba_pkg::FIFO_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == dba_pkg::FIFO_PTR_W'(dba_pkg::FIFO_DEPTH - 1))
                      ? '0 : wptr_reg + dba_pkg::FIFO_PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == dba_pkg::FIFO_PTR_W'(dba_pkg::FIFO_DEPTH - 1))
                      ? '0 : rptr_reg + dba_pkg::FIFO_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + dba_pkg::FIFO_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - dba_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

endmodule

[rtl/dba_back.sv]
// Back end: restoring divider for sum / count and the result output register.
// Pops frame totals from the queue; uses dba_pkg.
module dba_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dba_pkg::fifo_status_t         q_status,
    input  dba_pkg::frame_sum_t           pop_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dba_pkg::OUT_W-1:0]     m_tdata
);

    dba_pkg::div_state_t            state_reg;
    dba_pkg::div_state_t            state_next;
    logic [dba_pkg::REM_W-1:0]      rem_reg;
    logic [dba_pkg::REM_W-1:0]      rem_next;
    logic [dba_pkg::AVG_W-1:0]      quo_reg;
    logic [dba_pkg::AVG_W-1:0]      quo_next;
    logic [dba_pkg::COUNT_W-1:0]    div_reg;
    logic [dba_pkg::COUNT_W-1:0]    div_next;
    logic [dba_pkg::STEP_W-1:0]     step_reg;
    logic [dba_pkg::STEP_W-1:0]     step_next;
    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic [dba_pkg::AVG_W-1:0]      avg_reg;
    logic [dba_pkg::AVG_W-1:0]      avg_next;
    logic [dba_pkg::COUNT_W-1:0]    cnt_reg;
    logic [dba_pkg::COUNT_W-1:0]    cnt_next;
    logic [dba_pkg::REM_W:0]        trial;
    logic                           fits;
    logic                           load_out;

    // Quotient fits in AVG_W bits, so the upper sum bits are already below the divisor
    assign trial = {rem_reg, quo_reg[dba_pkg::AVG_W-1]};
    assign fits  = (trial >= (dba_pkg::REM_W+1)'(div_reg));

    assign pop      = (state_reg == dba_pkg::ST_IDLE) && !q_status.empty;
    assign load_out = (state_reg == dba_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        case (state_reg)
            dba_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    div_next  = pop_data.count;
                    rem_next  = dba_pkg::REM_W'(pop_data.sum >> dba_pkg::AVG_W);
                    quo_next  = pop_data.sum[dba_pkg::AVG_W-1:0];
                    step_next = dba_pkg::STEP_W'(dba_pkg::AVG_W - 1);
                    if (pop_data.count == '0)
                    begin
                        quo_next   = '0;
                        state_next = dba_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = dba_pkg::ST_DIV;
                    end
                end
            end
            dba_pkg::ST_DIV:
            begin
                rem_next = fits ? dba_pkg::REM_W'(trial - (dba_pkg::REM_W+1)'(div_reg))
                                : dba_pkg::REM_W'(trial);
                quo_next = {quo_reg[dba_pkg::AVG_W-2:0], fits};
                step_next = step_reg - dba_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = dba_pkg::ST_DONE;
                end
            end
            dba_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = dba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        avg_next      = avg_reg;
        cnt_next      = cnt_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            avg_next      = quo_reg;
            cnt_next      = div_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = dba_pkg::OUT_W'({cnt_reg, avg_reg});

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        step_reg <= step_next;
        avg_reg  <= avg_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dba_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dba_pkg::ST_DIV) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (div_reg == '0)) |-> (quo_reg == '0))
        else $error("nonzero average for empty band");

endmodule

[rtl/depth_band_average_core.sv]
// Top level of the depth band average core: front end, frame queue, divider.
// Depends on dba_pkg, dba_front, dba_fifo and dba_back.
//
//  channel  | signals                               | content
//  ---------+---------------------------------------+----------------------------------
//  input    | s_tvalid s_tready s_tdata s_tlast     | depth sample, last pixel of frame
//  output   | m_tvalid m_tready m_tdata             | average depth, in-band count
//  config   | cfg_wen cfg_index cfg_data            | 0 near threshold, 1 far threshold
//
// The front end takes one sample per cycle while the queue is not full and accumulates in the same cycle.
// Each frame end queues its totals (two frames deep); the divider then handles
// each frame in turn: one pop, 14 restoring steps, one output load, then the next.
// A full queue drops s_tready, so a run of short frames stalls the input.
// Reset clears accumulators, queue and output valid; thresholds return to 200 and 1000.
module depth_band_average_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [dba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dba_pkg::THRESH_W-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dba_pkg::DEPTH_W-1:0]       s_tdata,   // [15:0] depth_sample
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dba_pkg::OUT_W-1:0]         m_tdata    // [13:0] average_depth,
                                                         // [32:14] band_pixel_count
);

    dba_pkg::fifo_status_t q_status;
    dba_pkg::frame_sum_t   push_data;
    dba_pkg::frame_sum_t   pop_data;
    logic                  push;
    logic                  pop;

    dba_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    dba_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    dba_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
